FILE: src/hfmt_pkg.sv
// Shared types, constants and the microcode ROM of the hex float text formatter.
// Used by hfmt_seq and hex_float_text_formatter_unit; depends on nothing.
package hfmt_pkg;

  // Format limits
  localparam int MAX_FRACTION_DIGITS = 52;
  localparam int MANT_BITS           = 52;
  localparam int MANT_DIGITS         = 13;
  localparam int EXP_BITS            = 11;
  localparam int EMAG_BITS           = 10;
  localparam int PC_W                = 5;

  localparam logic [EXP_BITS-1:0]  EXP_ALL_ONES  = 11'h7FF;
  localparam logic [EXP_BITS-1:0]  EXP_BIAS      = 11'd1023;
  localparam logic [EMAG_BITS-1:0] SUBNORMAL_EXP = 10'd1022;

  // ASCII codes (letters in lower case; upper case folds bit 5)
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Channel words
  typedef struct packed {
    logic [63:0] value_bits;
    logic        shortest;
    logic [5:0]  digit_count;
    logic        upper_case;
    logic        alt_form;
    logic        plus_sign;
    logic        space_sign;
  } in_word_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } out_word_t;

  // Microcode fields
  typedef enum logic [2:0] {
    OP_NONE, OP_PREP0, OP_PREP1, OP_PREP2, OP_FRAC
  } op_t;

  typedef enum logic [3:0] {
    SEL_SIGN, SEL_ZERO, SEL_X, SEL_LEAD, SEL_DOT, SEL_FRAC, SEL_P, SEL_ESIGN,
    SEL_E3, SEL_E2, SEL_E1, SEL_E0, SEL_SPEC0, SEL_SPEC1, SEL_SPEC2
  } sel_t;

  typedef enum logic [2:0] {
    COND_ALWAYS, COND_SIGN, COND_DOT, COND_FRAC, COND_E4, COND_E3, COND_E2
  } cond_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_SPECIAL, JMP_LOOP, JMP_END
  } jump_t;

  typedef struct packed {
    op_t             op;
    sel_t            sel;
    cond_t           cond;
    logic            emit;
    logic            last;
    jump_t           jump;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic       special;
    logic       sign_en;
    logic       dot_en;
    logic       frac_en;
    logic       frac_more;
    logic [1:0] ndig;
  } flags_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic exec;
    op_t  op;
    logic fire;
    sel_t sel;
    logic last;
  } ctl_t;

  localparam logic [PC_W-1:0] STEP_SPEC0 = 5'd15;

  // Microcode ROM
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t u;
    u = '{op: OP_NONE, sel: SEL_ZERO, cond: COND_ALWAYS, emit: 1'b0, last: 1'b0,
          jump: JMP_END, target: '0};
    case (pc)
      5'd0:  begin u.op = OP_PREP0; u.jump = JMP_NEXT; end
      5'd1:  begin u.op = OP_PREP1; u.jump = JMP_NEXT; end
      5'd2:  begin u.op = OP_PREP2; u.jump = JMP_NEXT; end
      5'd3:  begin
        u.sel = SEL_SIGN; u.cond = COND_SIGN; u.emit = 1'b1;
        u.jump = JMP_SPECIAL; u.target = STEP_SPEC0;
      end
      5'd4:  begin u.sel = SEL_ZERO; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd5:  begin u.sel = SEL_X; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd6:  begin u.sel = SEL_LEAD; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd7:  begin u.sel = SEL_DOT; u.cond = COND_DOT; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd8:  begin
        u.op = OP_FRAC; u.sel = SEL_FRAC; u.cond = COND_FRAC; u.emit = 1'b1;
        u.jump = JMP_LOOP;
      end
      5'd9:  begin u.sel = SEL_P; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd10: begin u.sel = SEL_ESIGN; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd11: begin u.sel = SEL_E3; u.cond = COND_E4; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd12: begin u.sel = SEL_E2; u.cond = COND_E3; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd13: begin u.sel = SEL_E1; u.cond = COND_E2; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd14: begin u.sel = SEL_E0; u.emit = 1'b1; u.last = 1'b1; u.jump = JMP_END; end
      5'd15: begin u.sel = SEL_SPEC0; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd16: begin u.sel = SEL_SPEC1; u.emit = 1'b1; u.jump = JMP_NEXT; end
      5'd17: begin u.sel = SEL_SPEC2; u.emit = 1'b1; u.last = 1'b1; u.jump = JMP_END; end
      default: u.jump = JMP_END;
    endcase
    return u;
  endfunction

  // Letter case folding
  function automatic logic [7:0] fold_case(input logic [7:0] ch, input logic up);
    return up ? (ch & ~CASE_BIT) : ch;
  endfunction

  // One hex digit as ASCII
  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) c = CH_0 + {4'b0, d};
    else c = fold_case(CH_A + {4'b0, d - 4'd10}, up);
    return c;
  endfunction

endpackage

FILE: src/hfmt_seq.sv
// Microcode sequencer: step counter, ROM lookup, conditions and jumps.
// Depends on hfmt_pkg (ROM, control and flag types).
module hfmt_seq import hfmt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  logic   out_free,
  input  flags_t flags,
  output logic   busy,
  output ctl_t   ctl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            busy_next;
  ucode_t          u;
  logic            cond_true;
  logic            stall;

  // Current control word and its condition
  always_comb begin
    u = ucode(pc);
    case (u.cond)
      COND_ALWAYS: cond_true = 1'b1;
      COND_SIGN:   cond_true = flags.sign_en;
      COND_DOT:    cond_true = flags.dot_en;
      COND_FRAC:   cond_true = flags.frac_en;
      COND_E4:     cond_true = (flags.ndig == 2'd3);
      COND_E3:     cond_true = (flags.ndig >= 2'd2);
      COND_E2:     cond_true = (flags.ndig >= 2'd1);
      default:     cond_true = 1'b0;
    endcase
    stall    = busy && u.emit && cond_true && !out_free;
    ctl.exec = busy && !stall;
    ctl.op   = u.op;
    ctl.fire = busy && u.emit && cond_true && out_free;
    ctl.sel  = u.sel;
    ctl.last = u.last;
  end

  // Next step
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = '0;
      busy_next = 1'b1;
    end else if (busy && !stall) begin
      case (u.jump)
        JMP_NEXT:    pc_next = pc + 1'b1;
        JMP_SPECIAL: pc_next = flags.special ? u.target : pc + 1'b1;
        JMP_LOOP:    pc_next = (cond_true && flags.frac_more) ? pc : pc + 1'b1;
        JMP_END:     busy_next = 1'b0;
        default:     busy_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

FILE: src/hex_float_text_formatter_unit.sv
// Hex float text formatter, top level: input capture, datapath, output register.
// Depends on hfmt_pkg and hfmt_seq.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one word: a binary64 bit pattern
//   and the %a conversion flags. out channel (out_valid/out_ready/out_data) gives
//   the formatted text, one ASCII character per word, last_char set on the final one.
//   in_ready is high out of reset while no value is being formatted; one value is
//   worked on at a time. After acceptance a microcode sequencer runs its preparation
//   steps (rounding decision, rounding add, exponent decimal digits), then the text
//   steps, one step per cycle unless the receiver stalls, each step emitting at most
//   one character. The longest text has 63 characters. The sequencer stays busy
//   until the last character enters the output register, and in_ready returns when
//   it goes idle; inf and nan take a shorter step sequence.
//   A stalled receiver holds the output register and freezes the sequencer; no
//   character is lost. Reset clears the sequencer and the output valid flag;
//   no clearing pass is needed.
module hex_float_text_formatter_unit import hfmt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // Captured value and flags
  logic                  neg;
  logic                  up;
  logic                  alt;
  logic                  plus;
  logic                  space;
  logic                  shortest;
  logic [5:0]            cnt;
  logic [EXP_BITS-1:0]   ex;
  logic [MANT_BITS-1:0]  man;

  // Prepared state
  logic                  special;
  logic                  is_nan;
  logic [1:0]            lead;
  logic [5:0]            frac_left;
  logic                  rnd_inc;
  logic [EMAG_BITS-1:0]  emag;
  logic                  eneg;
  logic [6:0]            q1;
  logic [1:0]            ndig;
  logic [3:0]            d0;
  logic [3:0]            d1;
  logic [3:0]            d2;
  logic [3:0]            d3;

  logic   busy;
  logic   start;
  logic   out_free;
  flags_t flags;
  ctl_t   ctl;

  assign in_ready = !rst && !busy;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Rounding decision and shortest digit count
  logic       half;
  logic       sticky;
  logic       lsb_bit;
  logic       lsb;
  logic       round_next;
  logic [3:0] sig_digits;
  logic [MANT_BITS:0] inc;
  logic [MANT_BITS:0] sum;
  always_comb begin
    int n;
    int r;
    half       = 1'b0;
    sticky     = 1'b0;
    lsb_bit    = 1'b0;
    inc        = '0;
    for (int j = 0; j < MANT_BITS; j++) begin
      n = (MANT_BITS - 1 - j) / 4;
      r = (MANT_BITS - 1 - j) % 4;
      if (6'(n) == cnt && r == 0) half = half | man[j];
      if (6'(n) > cnt || (6'(n) == cnt && r != 0)) sticky = sticky | man[j];
      if (6'(n + 1) == cnt && r == 3) begin
        lsb_bit = lsb_bit | man[j];
        inc[j]  = 1'b1;
      end
    end
    inc[MANT_BITS] = (cnt == 6'd0);
    lsb        = (cnt == 6'd0) ? (ex != '0) : lsb_bit;
    round_next = !shortest && (cnt < 6'(MANT_DIGITS)) && half && (sticky || lsb);
    sum        = {1'b0, man} + inc;
    sig_digits = '0;
    for (int k = 0; k < MANT_DIGITS; k++) begin
      if (man[MANT_BITS - 1 - 4 * k -: 4] != 4'd0) sig_digits = 4'(k + 1);
    end
  end

  // Exponent magnitude and sign
  logic [EMAG_BITS-1:0] emag_next;
  logic                 eneg_next;
  always_comb begin
    if (ex == '0) begin
      emag_next = (man == '0) ? '0 : SUBNORMAL_EXP;
      eneg_next = (man != '0);
    end else if (ex >= EXP_BIAS) begin
      emag_next = EMAG_BITS'(ex - EXP_BIAS);
      eneg_next = 1'b0;
    end else begin
      emag_next = EMAG_BITS'(EXP_BIAS - ex);
      eneg_next = 1'b1;
    end
  end

  // Decimal digits: divide by ten as multiply by 205, shift by 11
  logic [17:0] prod1;
  logic [6:0]  q1_next;
  logic [9:0]  ten_q1;
  logic [14:0] prod2;
  logic [3:0]  q2;
  logic [6:0]  ten_q2;
  always_comb begin
    prod1   = 18'(emag) * 18'd205;
    q1_next = prod1[17:11];
    ten_q1  = ({3'b0, q1_next} << 3) + ({3'b0, q1_next} << 1);
    prod2   = 15'(q1) * 15'd205;
    q2      = prod2[14:11];
    ten_q2  = ({3'b0, q2} << 3) + ({3'b0, q2} << 1);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg      <= in_data.value_bits[63];
      ex       <= in_data.value_bits[62:52];
      man      <= in_data.value_bits[MANT_BITS-1:0];
      shortest <= in_data.shortest;
      cnt      <= (in_data.digit_count > 6'(MAX_FRACTION_DIGITS)) ?
                  6'(MAX_FRACTION_DIGITS) : in_data.digit_count;
      up       <= in_data.upper_case;
      alt      <= in_data.alt_form;
      plus     <= in_data.plus_sign;
      space    <= in_data.space_sign;
    end else if (ctl.exec) begin
      case (ctl.op)
        OP_PREP0: begin
          special   <= (ex == EXP_ALL_ONES);
          is_nan    <= (man != '0);
          lead      <= {1'b0, ex != '0};
          frac_left <= shortest ? {2'b0, sig_digits} : cnt;
          rnd_inc   <= round_next;
          emag      <= emag_next;
          eneg      <= eneg_next;
        end
        OP_PREP1: begin
          if (rnd_inc) begin
            man  <= sum[MANT_BITS-1:0];
            lead <= lead + {1'b0, sum[MANT_BITS]};
          end
          q1   <= q1_next;
          d0   <= 4'(emag - ten_q1);
          ndig <= (emag >= 10'd1000) ? 2'd3 :
                  (emag >= 10'd100)  ? 2'd2 :
                  (emag >= 10'd10)   ? 2'd1 : 2'd0;
        end
        OP_PREP2: begin
          d1 <= 4'(q1 - ten_q2);
          d3 <= (q2 >= 4'd10) ? 4'd1 : 4'd0;
          d2 <= (q2 >= 4'd10) ? q2 - 4'd10 : q2;
        end
        OP_FRAC: begin
          if (ctl.fire) begin
            man       <= {man[MANT_BITS-5:0], 4'b0};
            frac_left <= frac_left - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Status to the sequencer
  always_comb begin
    flags.special   = special;
    flags.sign_en   = neg || plus || space;
    flags.dot_en    = (frac_left != '0) || alt;
    flags.frac_en   = (frac_left != '0);
    flags.frac_more = (frac_left > 6'd1);
    flags.ndig      = ndig;
  end

  hfmt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .flags    (flags),
    .busy     (busy),
    .ctl      (ctl)
  );

  // Character select
  logic [7:0] ch;
  always_comb begin
    case (ctl.sel)
      SEL_SIGN:  ch = neg ? CH_MINUS : (plus ? CH_PLUS : CH_SPACE);
      SEL_ZERO:  ch = CH_0;
      SEL_X:     ch = fold_case(CH_X, up);
      SEL_LEAD:  ch = CH_0 + {6'b0, lead};
      SEL_DOT:   ch = CH_DOT;
      SEL_FRAC:  ch = hex_char(man[MANT_BITS-1 -: 4], up);
      SEL_P:     ch = fold_case(CH_P, up);
      SEL_ESIGN: ch = eneg ? CH_MINUS : CH_PLUS;
      SEL_E3:    ch = CH_0 + {4'b0, d3};
      SEL_E2:    ch = CH_0 + {4'b0, d2};
      SEL_E1:    ch = CH_0 + {4'b0, d1};
      SEL_E0:    ch = CH_0 + {4'b0, d0};
      SEL_SPEC0: ch = fold_case(is_nan ? CH_N : CH_I, up);
      SEL_SPEC1: ch = fold_case(is_nan ? CH_A : CH_N, up);
      SEL_SPEC2: ch = fold_case(is_nan ? CH_N : CH_F, up);
      default:   ch = CH_0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      out_data.text_char <= ch;
      out_data.last_char <= ctl.last;
    end
  end

endmodule

FILE: tb/hex_float_text_formatter_unit_tb.sv
// Self-checking testbench for the hex float text formatter: drives binary64 words with
// %a flags and checks every emitted character against typed text or a built-in predictor.
// Depends on hfmt_pkg and hex_float_text_formatter_unit.
module hex_float_text_formatter_unit_tb import hfmt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 84;
  localparam int HOLD_AT      = 500;      // char count at which the long receiver hold starts
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 60;       // random word after which the sender drains
  localparam int TAIL_CYCLES  = 80;
  localparam int MAX_SHOWN    = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  out_word_t pending_chars[$];   // characters still to come, oldest first
  in_word_t  dir_words[$];
  string     dir_texts[$];       // typed text, empty where the predictor is used
  bit        steady = 1'b0;      // no idling on either side while set
  int        char_count = 0;
  int        bad_count = 0;
  int        shown_count = 0;

  hex_float_text_formatter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // Failure bookkeeping
  function automatic void note_bad(input string msg);
    bad_count++;
    if (shown_count < MAX_SHOWN) begin
      shown_count++;
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  function automatic void put_char(input logic [7:0] c);
    out_word_t o;
    o.text_char = c;
    o.last_char = 1'b0;
    pending_chars.push_back(o);
  endfunction

  function automatic void mark_last();
    pending_chars[pending_chars.size() - 1].last_char = 1'b1;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) c = 8'("0") + 8'(d);
    else c = (up ? 8'("A") : 8'("a")) + 8'(d) - 8'd10;
    return c;
  endfunction

  function automatic void load_typed_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
    mark_last();
  endfunction

  // Text predictor: appends the %a text of one word to pending_chars
  function automatic void format_hex_float(input in_word_t w);
    logic [10:0] bexp;
    logic [63:0] man, low, half, kept;
    logic [3:0]  lead;
    logic        up, lsb;
    int          expo, frac, cnt, drop;
    int unsigned emag;
    string       edig;
    up   = w.upper_case;
    bexp = w.value_bits[62:52];
    man  = {12'd0, w.value_bits[51:0]};

    // sign bit alone decides minus, plus beats space
    if (w.value_bits[63]) put_char("-");
    else if (w.plus_sign) put_char("+");
    else if (w.space_sign) put_char(" ");

    // infinity and nan, payload ignored
    if (bexp == 11'h7FF) begin
      if (man == 0) begin
        put_char(up ? "I" : "i");
        put_char(up ? "N" : "n");
        put_char(up ? "F" : "f");
      end else begin
        put_char(up ? "N" : "n");
        put_char(up ? "A" : "a");
        put_char(up ? "N" : "n");
      end
      mark_last();
      return;
    end

    if (bexp == 0) begin
      lead = 4'd0;
      expo = (man == 0) ? 0 : -1022;
    end else begin
      lead = 4'd1;
      expo = int'(bexp) - 1023;
    end

    if (w.shortest) begin
      // trim trailing zero nibbles
      kept = man;
      frac = 13;
      while (frac > 0 && kept[3:0] == 4'd0) begin
        kept = kept >> 4;
        frac--;
      end
    end else begin
      cnt = int'(w.digit_count);
      if (cnt > 52) cnt = 52;
      if (cnt < 13) begin
        // round to nearest even, carry goes into the leading digit
        drop = 52 - cnt * 4;
        half = 64'd1 << (drop - 1);
        low  = man & ((64'd1 << drop) - 64'd1);
        kept = man >> drop;
        lsb  = (cnt == 0) ? lead[0] : kept[0];
        if (low > half || (low == half && lsb)) begin
          kept = kept + 64'd1;
          if (cnt == 0 || (kept >> (cnt * 4)) != 0) begin
            lead = lead + 4'd1;
            kept = 64'd0;
          end
        end
        man = kept << drop;
      end
      frac = cnt;
    end

    put_char("0");
    put_char(up ? "X" : "x");
    put_char(digit_char(lead, up));

    if (frac > 0 || w.alt_form) begin
      put_char(".");
      for (int i = 0; i < frac; i++) begin
        if (i <= 12) put_char(digit_char(4'((man >> (48 - i * 4)) & 64'hF), up));
        else put_char("0");
      end
    end

    put_char(up ? "P" : "p");
    if (expo >= 0) begin
      put_char("+");
      emag = expo;
    end else begin
      put_char("-");
      emag = -expo;
    end
    edig = $sformatf("%0d", emag);
    for (int i = 0; i < edig.len(); i++) put_char(edig[i]);
    mark_last();
  endfunction

  function automatic in_word_t mk(input logic [63:0] bits, input int sh,
                                  input int cnt, input int up, input int alt,
                                  input int pl, input int sp);
    in_word_t w;
    w.value_bits  = bits;
    w.shortest    = 1'(sh);
    w.digit_count = 6'(cnt);
    w.upper_case  = 1'(up);
    w.alt_form    = 1'(alt);
    w.plus_sign   = 1'(pl);
    w.space_sign  = 1'(sp);
    return w;
  endfunction

  function automatic void add_row(input in_word_t w, input string txt);
    dir_words.push_back(w);
    dir_texts.push_back(txt);
  endfunction

  // Random word, biased toward zeros and subnormals, specials, trimmed fractions, rounding ties and long digit counts
  function automatic in_word_t random_word();
    in_word_t    w;
    logic [63:0] m64, mask;
    int          kind, k, drop;
    w = mk({$urandom, $urandom}, $urandom_range(0, 1), $urandom_range(0, 63),
           $urandom_range(0, 1), $urandom_range(0, 1),
           $urandom_range(0, 1), $urandom_range(0, 1));
    m64 = {12'd0, w.value_bits[51:0]};
    kind = $urandom_range(0, 9);
    case (kind)
      2: begin
        w.value_bits[62:52] = 11'd0;
        if ($urandom_range(0, 1) == 0) m64 = 64'd0;
      end
      3: begin
        w.value_bits[62:52] = 11'h7FF;
        if ($urandom_range(0, 1) == 0) m64 = 64'd0;
      end
      4, 5: begin
        k    = $urandom_range(1, 13);
        mask = (64'd1 << (k * 4)) - 64'd1;
        m64  = m64 & ~mask;
        w.shortest = 1'b1;
      end
      6, 7: begin
        k    = $urandom_range(0, 12);
        drop = 52 - k * 4;
        mask = (64'd1 << drop) - 64'd1;
        m64  = (m64 & ~mask) | (64'd1 << (drop - 1));
        if ($urandom_range(0, 3) == 0) m64 = m64 | 64'd1;
        w.shortest    = 1'b0;
        w.digit_count = 6'(k);
      end
      8: begin
        w.value_bits[62:52] = 11'(1023 + $urandom_range(0, 20) - 10);
        w.shortest    = 1'b0;
        w.digit_count = 6'($urandom_range(13, 63));
      end
      default: ;
    endcase
    w.value_bits[51:0] = m64[51:0];
    return w;
  endfunction

  // Send one word; drain waits for every expected char before moving on
  task automatic send_word(input in_word_t w, input string txt, input bit drain);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (txt.len() != 0) load_typed_text(txt);
    else format_hex_float(w);
    if (drain) begin
      in_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clk);
    end else begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: random stalls, one long hold, checks each char in order
  initial begin
    int        stall;
    bit        held;
    out_word_t want;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (!held && char_count >= HOLD_AT) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      char_count++;
      if (pending_chars.size() == 0) begin
        note_bad($sformatf("unexpected char 0x%02h last %0b",
                           out_data.text_char, out_data.last_char));
      end else begin
        want = pending_chars.pop_front();
        if (out_data.text_char !== want.text_char || out_data.last_char !== want.last_char)
          note_bad($sformatf("char mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                             want.text_char, want.last_char,
                             out_data.text_char, out_data.last_char));
      end
    end
  end

  // Stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows: signs, specials, extremes, rounding ties and carries
    add_row(mk(64'h0000000000000000, 1, 0, 0, 0, 0, 0), "0x0p+0");
    add_row(mk(64'h8000000000000000, 1, 0, 0, 0, 1, 1), "-0x0p+0");
    add_row(mk(64'h7FF0000000000000, 1, 0, 0, 0, 0, 0), "inf");
    add_row(mk(64'hFFF0000000000000, 0, 7, 1, 1, 0, 0), "-INF");
    add_row(mk(64'hFFF8000000000000, 1, 0, 1, 0, 1, 0), "-NAN");
    add_row(mk(64'h7FF0000000000001, 1, 0, 0, 0, 1, 0), "+nan");
    add_row(mk(64'h3FF0000000000000, 1, 0, 0, 0, 0, 1), " 0x1p+0");
    add_row(mk(64'h3FF0000000000000, 1, 0, 0, 0, 1, 1), "+0x1p+0");
    add_row(mk(64'h3FF0000000000000, 1, 0, 0, 1, 0, 0), "0x1.p+0");
    add_row(mk(64'h7FEFFFFFFFFFFFFF, 1, 0, 1, 0, 0, 0), "0X1.FFFFFFFFFFFFFP+1023");
    add_row(mk(64'h0000000000000001, 1, 0, 0, 0, 0, 0), "0x0.0000000000001p-1022");
    add_row(mk(64'h0010000000000000, 1, 0, 0, 0, 0, 0), "0x1p-1022");
    add_row(mk(64'h3FF8000000000000, 0, 0, 0, 0, 0, 0), "0x2p+0");
    add_row(mk(64'h3FF0800000000000, 0, 1, 0, 0, 0, 0), "0x1.0p+0");
    add_row(mk(64'h3FF1800000000000, 0, 1, 0, 0, 0, 0), "0x1.2p+0");
    add_row(mk(64'h3FFFF80000000000, 0, 1, 0, 0, 0, 0), "0x2.0p+0");
    add_row(mk(64'h000FFFFFFFFFFFFF, 0, 0, 0, 0, 0, 0), "0x1p-1022");
    add_row(mk(64'h3FE0000000000000, 1, 0, 0, 0, 0, 0), "0x1p-1");
    add_row(mk(64'h3FF0000000000000, 0, 0, 1, 1, 0, 0), "0X1.P+0");
    add_row(mk(64'h4000000000000000, 0, 0, 0, 0, 0, 0), "0x1p+1");
    add_row(mk(64'h3FF0000000000000, 0, 63, 0, 0, 0, 0), "");
    add_row(mk(64'h7FEFFFFFFFFFFFFF, 0, 52, 1, 0, 1, 0), "");
    add_row(mk(64'h3FF123456789ABCD, 0, 13, 0, 0, 0, 0), "");
    add_row(mk(64'hBFF123456789ABCD, 0, 14, 1, 1, 0, 1), "");
    add_row(mk(64'h400921FB54442D18, 0, 5, 1, 1, 0, 0), "");
    add_row(mk(64'h800000000ABC0000, 1, 9, 0, 0, 0, 1), "");

    foreach (dir_words[i]) send_word(dir_words[i], dir_texts[i], 1'b0);

    // random words, with one no-idle stretch and one full drain
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 30 && i < 45);
      send_word(random_word(), "", i == DRAIN_AT);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0)
      note_bad($sformatf("%0d chars never arrived", pending_chars.size()));

    if (bad_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
